FILE: hdl/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared constants for the TTL/LFU cache table: field widths, operation
// codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package ttl_pkg;

  localparam int unsigned TimeBits   = 32;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned HandleW    = 32;
  localparam int unsigned LengthW    = 10;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned CountW     = 7;
  localparam int unsigned HitsW      = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_TTL      = 1'b1;

  localparam logic [CountW-1:0]   CAPACITY_RESET = 7'd64;
  localparam logic [TimeBits-1:0] TTL_RESET      = 32'd86400;

endpackage

FILE: hdl/ttl_req_if.sv
// ----------------------------------------------------------------------------
// ttl_req_if
// Request channel of the cache table: one lookup or insert per item.
// ----------------------------------------------------------------------------
interface ttl_req_if
  import ttl_pkg::*;
();

  logic                valid;
  logic                ready;
  logic                op;
  logic [TimeBits-1:0] now;
  logic [KeyW-1:0]     key;
  logic [HandleW-1:0]  payload_handle;
  logic [LengthW-1:0]  payload_length;

  modport source (
    output valid, op, now, key, payload_handle, payload_length,
    input  ready
  );

  modport sink (
    input  valid, op, now, key, payload_handle, payload_length,
    output ready
  );

endinterface

FILE: hdl/ttl_rsp_if.sv
// ----------------------------------------------------------------------------
// ttl_rsp_if
// Response channel of the cache table: one result item per request.
// ----------------------------------------------------------------------------
interface ttl_rsp_if
  import ttl_pkg::*;
();

  logic               valid;
  logic               ready;
  logic               found;
  logic [SlotW-1:0]   slot;
  logic               replaced;
  logic [HandleW-1:0] answer_handle;
  logic [LengthW-1:0] answer_length;
  logic [CountW-1:0]  entry_count;

  modport source (
    output valid, found, slot, replaced, answer_handle, answer_length, entry_count,
    input  ready
  );

  modport sink (
    input  valid, found, slot, replaced, answer_handle, answer_length, entry_count,
    output ready
  );

endinterface

FILE: hdl/ttl_lfu_cache_table_unit.sv
// ----------------------------------------------------------------------------
// ttl_lfu_cache_table_unit
// Answer cache with time-to-live expiry and least-frequently-used replacement.
// ----------------------------------------------------------------------------
// All entries live in one single-port-read, single-port-write memory with a
// registered read. Each request walks the occupied entries in order, one read
// per cycle, visiting up to the occupied count (fewer when a lookup hits or an
// insert finds an expired entry early); an empty table skips the scan. The
// memory read port sets this pace.
// A lookup hit writes the bumped hit count back in the cycle it is found; an
// insert writes its entry once the scan has picked the slot. The result sits
// in an output register, and the next request is taken once the previous one
// has been handed to that register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ttl_lfu_cache_table_unit
  import ttl_pkg::*;
#(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  ttl_req_if.sink             req,
  ttl_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CountW) ? CW : CountW;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TimeBits-1:0] expiry;
    logic [HitsW-1:0]    hits;
    logic [HandleW-1:0]  handle;
    logic [LengthW-1:0]  length;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  entry_t mem [DEPTH];
  entry_t rd_data;

  state_t              state;
  logic [CountW-1:0]   capacity;
  logic [TimeBits-1:0] ttl_seconds;
  logic [CW-1:0]       count;

  logic                op_q;
  logic [TimeBits-1:0] now_q;
  logic [KEY_BITS-1:0] key_q;
  logic [HandleW-1:0]  handle_q;
  logic [LengthW-1:0]  length_q;

  logic [CW-1:0]       issue_idx;
  logic [CW-1:0]       chk_idx;
  logic                chk_vld;

  logic                found_q;
  logic [AW-1:0]       slot_q;
  logic [HandleW-1:0]  hand_q;
  logic [LengthW-1:0]  len_q;

  logic                exp_found;
  logic                have_cand;
  logic [HitsW-1:0]    min_hits;
  logic [TimeBits-1:0] min_exp;
  logic [AW-1:0]       cand;

  logic                out_vld;
  logic                out_found;
  logic [SlotW-1:0]    out_slot;
  logic                out_replaced;
  logic [HandleW-1:0]  out_handle;
  logic [LengthW-1:0]  out_length;
  logic [CountW-1:0]   out_count;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  logic                live;
  logic                key_match;
  logic                last_chk;
  logic                better_cand;
  logic                lookup_hit;
  logic                out_free;
  logic                do_append;
  logic [AW-1:0]       ins_slot;
  logic [CMPW-1:0]     eff_cap;
  logic [TimeBits:0]   exp_sum;
  logic [TimeBits-1:0] exp_sat;
  logic [HitsW-1:0]    hits_inc;
  logic                cfg_wr;

  // ---- combinational scan and decision logic
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(capacity) > CMPW'(DEPTH)) begin
      eff_cap = CMPW'(DEPTH);
    end else begin
      eff_cap = CMPW'(capacity);
    end
  end

  assign live        = !(rd_data.expiry < now_q);
  assign key_match   = (rd_data.key == key_q);
  assign last_chk    = ((chk_idx + CW'(1)) == count);
  assign better_cand = !have_cand || (rd_data.hits < min_hits) ||
                       ((rd_data.hits == min_hits) && (rd_data.expiry <= min_exp));
  assign lookup_hit  = (state == ST_SCAN) && chk_vld && (op_q == OP_LOOKUP) &&
                       live && key_match;
  assign hits_inc    = (rd_data.hits == '1) ? rd_data.hits : rd_data.hits + HitsW'(1);

  assign out_free  = !out_vld || rsp.ready;
  assign do_append = !exp_found && (CMPW'(count) < eff_cap);
  assign ins_slot  = do_append ? AW'(count) : cand;
  assign exp_sum   = {1'b0, now_q} + {1'b0, ttl_seconds};
  assign exp_sat   = exp_sum[TimeBits] ? '1 : exp_sum[TimeBits-1:0];

  assign rd_en   = (state == ST_SCAN) && (issue_idx < count);
  assign rd_addr = issue_idx[AW-1:0];

  always_comb begin
    wr_data = rd_data;
    wr_addr = ins_slot;
    wr_en   = 1'b0;
    if (lookup_hit) begin
      wr_en        = 1'b1;
      wr_addr      = chk_idx[AW-1:0];
      wr_data.hits = hits_inc;
    end else if ((state == ST_DONE) && (op_q == OP_INSERT) && out_free) begin
      wr_en          = 1'b1;
      wr_data.key    = key_q;
      wr_data.expiry = exp_sat;
      wr_data.hits   = HitsW'(1);
      wr_data.handle = handle_q;
      wr_data.length = length_q;
    end
  end

  // ---- entry memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // ---- config port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TTL) ? ttl_seconds : ApbDataW'(capacity);

  // ---- control, scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      capacity    <= CAPACITY_RESET;
      ttl_seconds <= TTL_RESET;
      count       <= '0;
      chk_vld     <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_CAPACITY) begin
          capacity <= pwdata[CountW-1:0];
        end else begin
          ttl_seconds <= pwdata[TimeBits-1:0];
        end
      end

      if (rsp.valid && rsp.ready && (state != ST_DONE)) begin
        out_vld <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op_q      <= req.op;
            now_q     <= req.now;
            key_q     <= req.key[KEY_BITS-1:0];
            handle_q  <= req.payload_handle;
            length_q  <= req.payload_length;
            issue_idx <= '0;
            chk_vld   <= 1'b0;
            exp_found <= 1'b0;
            have_cand <= 1'b0;
            cand      <= '0;
            found_q   <= 1'b0;
            slot_q    <= '0;
            hand_q    <= '0;
            len_q     <= '0;
            state     <= (count == '0) ? ST_DONE : ST_SCAN;
          end
        end

        ST_SCAN: begin
          chk_vld <= rd_en;
          chk_idx <= issue_idx;
          if (rd_en) begin
            issue_idx <= issue_idx + CW'(1);
          end
          if (chk_vld) begin
            if (op_q == OP_LOOKUP) begin
              if (live && key_match) begin
                found_q <= 1'b1;
                slot_q  <= chk_idx[AW-1:0];
                hand_q  <= rd_data.handle;
                len_q   <= rd_data.length;
                state   <= ST_DONE;
              end else if (last_chk) begin
                state <= ST_DONE;
              end
            end else begin
              if (!live) begin
                exp_found <= 1'b1;
                cand      <= chk_idx[AW-1:0];
                state     <= ST_DONE;
              end else begin
                if (better_cand) begin
                  have_cand <= 1'b1;
                  min_hits  <= rd_data.hits;
                  min_exp   <= rd_data.expiry;
                  cand      <= chk_idx[AW-1:0];
                end
                if (last_chk) begin
                  state <= ST_DONE;
                end
              end
            end
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_vld <= 1'b1;
            if (op_q == OP_LOOKUP) begin
              out_found    <= found_q;
              out_slot     <= SlotW'(slot_q);
              out_replaced <= 1'b0;
              out_handle   <= hand_q;
              out_length   <= len_q;
              out_count    <= CountW'(count);
            end else begin
              out_found    <= 1'b1;
              out_slot     <= SlotW'(ins_slot);
              out_replaced <= !do_append;
              out_handle   <= '0;
              out_length   <= '0;
              if (do_append) begin
                count     <= count + CW'(1);
                out_count <= CountW'(count + CW'(1));
              end else begin
                out_count <= CountW'(count);
              end
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_vld;
  assign rsp.found         = out_found;
  assign rsp.slot          = out_slot;
  assign rsp.replaced      = out_replaced;
  assign rsp.answer_handle = out_handle;
  assign rsp.answer_length = out_length;
  assign rsp.entry_count   = out_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupied count above table depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != ST_IDLE))
    else $error("accepted item did not start work");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (((state == ST_SCAN) && (op_q == OP_LOOKUP)) ||
               ((state == ST_DONE) && (op_q == OP_INSERT))))
    else $error("memory write outside a lookup hit or insert commit");

  a_check_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN) && chk_vld) |-> (chk_idx < count))
    else $error("scan checked an entry beyond the occupied count");

  a_done_to_output: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_free) |=> (out_vld && (state == ST_IDLE)))
    else $error("finished item not moved to output register");
`endif

endmodule

FILE: tb/sv/ttl_lfu_cache_table_unit_test.sv
// ----------------------------------------------------------------------------
// ttl_lfu_cache_table_unit_test
// Self-checking bench for the TTL/LFU answer cache. A directed table walks
// empty-table misses, field extremes, expiry at the boundary, replacement of
// expired entries, duplicate keys, saturating expiry and out-of-range
// capacity. Randomized phases follow, each with its own capacity and TTL,
// drawing keys from a small pool so that lookups hit, entries expire and
// the least-used entry gets evicted. A local model of the table predicts
// every response. Both channels stall at random.
// ----------------------------------------------------------------------------
module ttl_lfu_cache_table_unit_test;
  import ttl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL_SIZE   = 12;

  typedef struct packed {
    logic               found;
    logic [SlotW-1:0]   slot;
    logic               replaced;
    logic [HandleW-1:0] handle;
    logic [LengthW-1:0] length;
    logic [CountW-1:0]  count;
  } cache_result_t;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic                op;
    logic [TimeBits-1:0] now;
    logic [KeyW-1:0]     key;
    logic [HandleW-1:0]  handle;
    logic [LengthW-1:0]  length;
    logic                reg_idx;
    logic [ApbDataW-1:0] reg_value;
    bit                  golden;
    cache_result_t       want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ttl_req_if req_ch ();
  ttl_rsp_if rsp_ch ();

  ttl_lfu_cache_table_unit uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // cache model state
  logic [KeyW-1:0]     cache_keys    [TABLE_DEPTH];
  logic [TimeBits-1:0] cache_expiry  [TABLE_DEPTH];
  logic [HitsW-1:0]    cache_hits    [TABLE_DEPTH];
  logic [HandleW-1:0]  cache_handles [TABLE_DEPTH];
  logic [LengthW-1:0]  cache_lengths [TABLE_DEPTH];
  int                  cache_count;
  logic [CountW-1:0]   cfg_capacity;
  logic [TimeBits-1:0] cfg_ttl;

  cache_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int            mismatch_count = 0;
  bit            req_idle = 1'b1;
  bit            rsp_idle = 1'b1;

  int unsigned phase_caps [10] = '{4, 1, 8, 0, 3, 127, 2, 6, 64, 127};
  int unsigned phase_ttls [10] = '{20, 8, 0, 50, 15, 300, 5, 1000, 86400, 32'hFFFF_FFFF};

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic int pick_gap(input bit enabled);
    int roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cache_result_t predict_cache_access(
    input logic                op,
    input logic [TimeBits-1:0] now,
    input logic [KeyW-1:0]     key,
    input logic [HandleW-1:0]  handle,
    input logic [LengthW-1:0]  length
  );
    cache_result_t       r;
    logic [TimeBits:0]   sum;
    logic [TimeBits-1:0] expiry;
    logic [HitsW-1:0]    min_hits;
    logic [TimeBits-1:0] min_exp;
    int                  cand;
    int                  target;
    int                  eff_cap;
    bit                  expired_seen;
    bit                  have_cand;
    r = '0;
    cand = 0;
    min_hits = '0;
    min_exp = '0;
    expired_seen = 1'b0;
    have_cand = 1'b0;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < cache_count; i++) begin
        if (cache_expiry[i] < now) continue;
        if (cache_keys[i] == key) begin
          if (cache_hits[i] != '1) cache_hits[i] = cache_hits[i] + 1'b1;
          r.found = 1'b1;
          r.slot = i[SlotW-1:0];
          r.handle = cache_handles[i];
          r.length = cache_lengths[i];
          break;
        end
      end
    end else begin
      sum = {1'b0, now} + {1'b0, cfg_ttl};
      expiry = sum[TimeBits] ? '1 : sum[TimeBits-1:0];
      for (int i = 0; i < cache_count; i++) begin
        if (cache_expiry[i] < now) begin
          expired_seen = 1'b1;
          cand = i;
          break;
        end
        if (!have_cand || cache_hits[i] < min_hits ||
            (cache_hits[i] == min_hits && cache_expiry[i] <= min_exp)) begin
          have_cand = 1'b1;
          min_hits = cache_hits[i];
          min_exp = cache_expiry[i];
          cand = i;
        end
      end
      eff_cap = (cfg_capacity == 0) ? 1 :
                (cfg_capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_capacity);
      if (!expired_seen && cache_count < eff_cap) begin
        target = cache_count;
        cache_count++;
      end else begin
        target = cand;
        r.replaced = 1'b1;
      end
      cache_keys[target] = key;
      cache_expiry[target] = expiry;
      cache_hits[target] = HitsW'(1);
      cache_handles[target] = handle;
      cache_lengths[target] = length;
      r.found = 1'b1;
      r.slot = target[SlotW-1:0];
    end
    r.count = cache_count[CountW-1:0];
    return r;
  endfunction

  function automatic cache_result_t mk_result(
    input logic found, input int slot, input logic replaced,
    input logic [HandleW-1:0] handle, input logic [LengthW-1:0] length, input int count
  );
    cache_result_t r;
    r.found = found;
    r.slot = slot[SlotW-1:0];
    r.replaced = replaced;
    r.handle = handle;
    r.length = length;
    r.count = count[CountW-1:0];
    return r;
  endfunction

  function automatic stim_row_t req_row(
    input logic op, input logic [TimeBits-1:0] now, input logic [KeyW-1:0] key,
    input logic [HandleW-1:0] handle, input logic [LengthW-1:0] length
  );
    stim_row_t row;
    row = '{kind: ROW_REQUEST, default: '0};
    row.op = op;
    row.now = now;
    row.key = key;
    row.handle = handle;
    row.length = length;
    return row;
  endfunction

  function automatic stim_row_t gold_row(input stim_row_t row, input cache_result_t want);
    stim_row_t r;
    r = row;
    r.golden = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [ApbDataW-1:0] value);
    stim_row_t row;
    row = '{kind: ROW_REGISTER, default: '0};
    row.reg_idx = idx;
    row.reg_value = value;
    return row;
  endfunction

  task automatic issue_request(
    input logic op, input logic [TimeBits-1:0] now, input logic [KeyW-1:0] key,
    input logic [HandleW-1:0] handle, input logic [LengthW-1:0] length,
    input bit golden, input cache_result_t want
  );
    int            gap;
    cache_result_t predicted;
    gap = pick_gap(req_idle);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.now <= now;
    req_ch.key <= key;
    req_ch.payload_handle <= handle;
    req_ch.payload_length <= length;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_cache_access(op, now, key, handle, length);
    pending_results.push_back(golden ? want : predicted);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ApbAddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_CAPACITY) cfg_capacity = value[CountW-1:0];
    else cfg_ttl = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== value)
      report_mismatch($sformatf("register %0d readback %h, wrote %h", idx, readback, value));
  endtask

  task automatic check_result();
    cache_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result item with nothing pending");
      return;
    end
    want = pending_results.pop_front();
    if (rsp_ch.found !== want.found)
      report_mismatch($sformatf("found %b, want %b", rsp_ch.found, want.found));
    if (rsp_ch.slot !== want.slot)
      report_mismatch($sformatf("slot %0d, want %0d", rsp_ch.slot, want.slot));
    if (rsp_ch.replaced !== want.replaced)
      report_mismatch($sformatf("replaced %b, want %b", rsp_ch.replaced, want.replaced));
    if (rsp_ch.answer_handle !== want.handle)
      report_mismatch($sformatf("answer_handle %h, want %h", rsp_ch.answer_handle, want.handle));
    if (rsp_ch.answer_length !== want.length)
      report_mismatch($sformatf("answer_length %0d, want %0d", rsp_ch.answer_length, want.length));
    if (rsp_ch.entry_count !== want.count)
      report_mismatch($sformatf("entry_count %0d, want %0d", rsp_ch.entry_count, want.count));
  endtask

  // response side
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_gap(rsp_idle);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      check_result();
    end
  end

  initial begin
    #8000000;
    $display("ttl_lfu_cache_table_unit regression: fail");
    $finish;
  end

  // request side and register writes
  initial begin
    logic [KeyW-1:0]     key_pool [POOL_SIZE];
    logic [TimeBits-1:0] sim_now;
    logic [KeyW-1:0]     key;
    logic                op;
    logic [LengthW-1:0]  length;
    int                  roll;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op <= OP_LOOKUP;
    req_ch.now <= '0;
    req_ch.key <= '0;
    req_ch.payload_handle <= '0;
    req_ch.payload_length <= '0;

    cache_count = 0;
    cfg_capacity = CAPACITY_RESET;
    cfg_ttl = TTL_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, extremes, expiry boundary
    directed_rows.push_back(gold_row(req_row(OP_LOOKUP, 0, '0, 0, 0),
                                     mk_result(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(gold_row(req_row(OP_INSERT, 0, '0, 0, 0),
                                     mk_result(1, 0, 0, 0, 0, 1)));
    directed_rows.push_back(gold_row(req_row(OP_INSERT, 0, '1, '1, '1),
                                     mk_result(1, 1, 0, 0, 0, 2)));
    directed_rows.push_back(gold_row(req_row(OP_LOOKUP, 100, '1, 0, 0),
                                     mk_result(1, 1, 0, '1, '1, 2)));
    directed_rows.push_back(gold_row(req_row(OP_LOOKUP, 86400, '0, 0, 0),
                                     mk_result(1, 0, 0, 0, 0, 2)));
    directed_rows.push_back(gold_row(req_row(OP_LOOKUP, 86401, '0, 0, 0),
                                     mk_result(0, 0, 0, 0, 0, 2)));
    // expired entries reused first, duplicate key
    directed_rows.push_back(gold_row(req_row(OP_INSERT, 86401, 64'h5, 32'h1234, 512),
                                     mk_result(1, 0, 1, 0, 0, 2)));
    directed_rows.push_back(gold_row(req_row(OP_INSERT, 86401, 64'h5, 32'hAAAA, 7),
                                     mk_result(1, 1, 1, 0, 0, 2)));
    directed_rows.push_back(gold_row(req_row(OP_LOOKUP, 86401, 64'h5, 0, 0),
                                     mk_result(1, 0, 0, 32'h1234, 512, 2)));
    // expiry sum saturates
    directed_rows.push_back(cfg_row(REG_TTL, 32'hFFFF_FFFF));
    directed_rows.push_back(gold_row(req_row(OP_INSERT, 32'hFFFF_FFF0, 64'h77, 32'hDEAD_BEEF, 3),
                                     mk_result(1, 0, 1, 0, 0, 2)));
    directed_rows.push_back(gold_row(req_row(OP_LOOKUP, 32'hFFFF_FFFF, 64'h77, 0, 0),
                                     mk_result(1, 0, 0, 32'hDEAD_BEEF, 3, 2)));
    // capacity zero and below the count, zero TTL
    directed_rows.push_back(cfg_row(REG_CAPACITY, 0));
    directed_rows.push_back(cfg_row(REG_TTL, 0));
    directed_rows.push_back(req_row(OP_INSERT, 32'hFFFF_FFFF, 64'h99, 1, 1));
    directed_rows.push_back(req_row(OP_INSERT, 5, 64'hA1, 2, 2));
    directed_rows.push_back(req_row(OP_INSERT, 5, 64'hA2, 3, 3));
    directed_rows.push_back(req_row(OP_LOOKUP, 5, 64'hA2, 0, 0));
    // capacity above depth
    directed_rows.push_back(cfg_row(REG_CAPACITY, 127));
    directed_rows.push_back(cfg_row(REG_TTL, 100));
    directed_rows.push_back(req_row(OP_INSERT, 6, 64'hB1, 4, 4));
    directed_rows.push_back(req_row(OP_LOOKUP, 200, 64'hB1, 0, 0));
    directed_rows.push_back(req_row(OP_LOOKUP, 7, 64'h1234, 0, 0));
    // hit and expiry ties
    directed_rows.push_back(cfg_row(REG_CAPACITY, 3));
    directed_rows.push_back(cfg_row(REG_TTL, 10));
    directed_rows.push_back(req_row(OP_INSERT, 7, 64'hC1, 5, 5));
    directed_rows.push_back(req_row(OP_INSERT, 7, 64'hC2, 6, 6));
    directed_rows.push_back(req_row(OP_INSERT, 7, 64'hC3, 7, 7));

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == ROW_REGISTER) begin
        drain_results();
        write_register(directed_rows[n].reg_idx, directed_rows[n].reg_value);
      end else begin
        issue_request(directed_rows[n].op, directed_rows[n].now, directed_rows[n].key,
                      directed_rows[n].handle, directed_rows[n].length,
                      directed_rows[n].golden, directed_rows[n].want);
      end
    end

    sim_now = 32'd1000;
    for (int p = 0; p < 10; p++) begin
      drain_results();
      write_register(REG_CAPACITY, phase_caps[p]);
      write_register(REG_TTL, phase_ttls[p]);
      req_idle = (p % 3 != 1);
      rsp_idle = (p % 4 != 2);
      for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
      if (p == 9) sim_now = 32'hFFFF_FF00;
      for (int n = 0; n < 95; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) sim_now = sim_now + $urandom_range(0, 3);
        else if (roll < 85) sim_now = sim_now + $urandom_range(4, 40);
        else if (roll < 95) sim_now = sim_now - $urandom_range(0, 10);
        else sim_now = $urandom;
        op = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_LOOKUP;
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : {$urandom, $urandom};
        length = ($urandom_range(0, 9) == 0) ? LengthW'($urandom_range(0, 1023))
                                             : LengthW'($urandom_range(0, 512));
        if ($urandom_range(0, 149) == 0 || (p == 5 && n == 47)) drain_results();
        issue_request(op, sim_now, key, $urandom, length, 1'b0, '0);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ttl_lfu_cache_table_unit regression: pass");
    end else begin
      $display("ttl_lfu_cache_table_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ttl_pkg.sv
hdl/ttl_req_if.sv
hdl/ttl_rsp_if.sv
hdl/ttl_lfu_cache_table_unit.sv
tb/sv/ttl_lfu_cache_table_unit_test.sv
